// ===== rtl/dct2_8_point_defines.svh =====
`ifndef DCT2_8_POINT_DEFINES_SVH
`define DCT2_8_POINT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DCT2_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dct2 check failed");

// antecedent implies consequent a fixed number of cycles later
`define DCT2_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("dct2 latency check failed");

// a result field stays within the symmetric saturation bound
`define DCT2_ASSERT_RANGE(lbl, vld, val, lim) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld) |-> (((val) <= (lim)) && ((val) >= -(lim)))) \
    else $error("dct2 range check failed");

`endif

// ===== rtl/dct2_pkg.sv =====
`default_nettype none

package dct2_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int OUT_BITS            = 20;
  localparam int OUT_LIMIT           = 262144;
  localparam int COEF_FRAC_BITS_DEF  = 15;

  // rotation and scaling constants, 30 fraction bits
  localparam int K30_SQRT1_2 = 759250125;
  localparam int K30_C1      = 1053110176;
  localparam int K30_S1      = 209476638;
  localparam int K30_C3      = 892783698;
  localparam int K30_S3      = 596538995;
  localparam int K30_C6      = 410903207;
  localparam int K30_S6      = 992008094;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    coef_t;

  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;
  } dct_in_t;

  typedef struct packed {
    coef_t coef_0;
    coef_t coef_1;
    coef_t coef_2;
    coef_t coef_3;
    coef_t coef_4;
    coef_t coef_5;
    coef_t coef_6;
    coef_t coef_7;
  } dct_out_t;

  // round a 30-fraction-bit constant half up to frac fraction bits
  function automatic int kcoef(input int k30, input int frac);
    return (k30 + (1 << (29 - frac))) >>> (30 - frac);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dct2_8_point.sv =====
// channel  ports                    beat taken when
// -------  -----------------------  ---------------------------
// input    start, busy, in_data     rising edge, start & !busy
// result   out_valid, out_data      rising edge, out_valid high
//
// seven register stages: butterflies, rotation products, rotation sums,
// scaling product, final sums, final products, round and saturate
// one beat per cycle, result leaves after all seven register stages
// busy is always low; results cannot be held off and leave as they finish
// synchronous active-low reset clears the valid chain only

`default_nettype none

`include "dct2_8_point_defines.svh"

module dct2_8_point import dct2_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dct_in_t  in_data,
  output logic          out_valid,
  output dct_out_t      out_data
);

  localparam int SW  = SAMPLE_BITS;
  localparam int W1  = SW + 1;
  localparam int W2  = SW + 2;
  localparam int W3  = SW + 3;
  localparam int W4  = SW + 4;
  localparam int KW  = COEF_FRAC_BITS + 1;
  localparam int PW  = W4 + KW;
  localparam int LAT = 7;

  localparam logic signed [KW-1:0] KC_SQ = KW'(kcoef(K30_SQRT1_2, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_C1 = KW'(kcoef(K30_C1, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_S1 = KW'(kcoef(K30_S1, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_C3 = KW'(kcoef(K30_C3, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_S3 = KW'(kcoef(K30_S3, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_C6 = KW'(kcoef(K30_C6, COEF_FRAC_BITS));
  localparam logic signed [KW-1:0] KC_S6 = KW'(kcoef(K30_S6, COEF_FRAC_BITS));

  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [W4-1:0] SAT_HI   = W4'(OUT_LIMIT);
  localparam logic signed [W4-1:0] SAT_LO   = -SAT_HI;
  localparam coef_t                COEF_HI  = OUT_BITS'(OUT_LIMIT);

  function automatic logic signed [PW-1:0] mulk(input logic signed [W4-1:0] a,
                                                 input logic signed [KW-1:0] k);
    return PW'(a) * PW'(k);
  endfunction

  // round to nearest, ties upward
  function automatic logic signed [W4-1:0] rnd(input logic signed [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + RND_HALF;
    return t[COEF_FRAC_BITS +: W4];
  endfunction

  function automatic coef_t sat(input logic signed [W4-1:0] v);
    if (v > SAT_HI) begin
      return OUT_BITS'(SAT_HI);
    end
    if (v < SAT_LO) begin
      return OUT_BITS'(SAT_LO);
    end
    return OUT_BITS'(v);
  endfunction

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  // stage 1
  logic signed [W1-1:0] st1_s07_r, st1_s16_r, st1_s25_r, st1_s34_r;
  logic signed [W1-1:0] st1_d07_r, st1_d16_r, st1_d25_r, st1_d34_r;
  // stage 2
  logic signed [W2-1:0] st2_e0_r, st2_e1_r, st2_f0_r, st2_f1_r;
  logic signed [PW-1:0] st2_p_r [8];
  // stage 3
  logic signed [W2-1:0] st3_ux_r, st3_uy_r, st3_vx_r, st3_vy_r;
  logic signed [W3-1:0] st3_a0_r, st3_b0_r;
  logic signed [PW-1:0] st3_q_r [4];
  // stage 4
  logic signed [W3-1:0] st4_a0_r, st4_c0_r, st4_d0_r;
  logic signed [W3-1:0] st4_a1_r, st4_b1_r, st4_c1_r, st4_d1_r;
  logic signed [PW-1:0] st4_pb_r;
  // stage 5
  logic signed [W3-1:0] st5_a0_r, st5_c0_r, st5_d0_r, st5_b1_r, st5_c1_r;
  logic signed [W4-1:0] st5_c4_r, st5_sa_r, st5_sd_r;
  // stage 6
  logic signed [W3-1:0] st6_a0_r, st6_c0_r, st6_d0_r, st6_b1_r, st6_c1_r;
  logic signed [W4-1:0] st6_c4_r;
  logic signed [PW-1:0] st6_pa_r, st6_pd_r;
  // stage 7
  dct_out_t out_data_r;

  coef_t dc_sum;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    // butterflies
    st1_s07_r <= W1'(in_data.sample_0) + W1'(in_data.sample_7);
    st1_d07_r <= W1'(in_data.sample_0) - W1'(in_data.sample_7);
    st1_s16_r <= W1'(in_data.sample_1) + W1'(in_data.sample_6);
    st1_d16_r <= W1'(in_data.sample_1) - W1'(in_data.sample_6);
    st1_s25_r <= W1'(in_data.sample_2) + W1'(in_data.sample_5);
    st1_d25_r <= W1'(in_data.sample_2) - W1'(in_data.sample_5);
    st1_s34_r <= W1'(in_data.sample_3) + W1'(in_data.sample_4);
    st1_d34_r <= W1'(in_data.sample_3) - W1'(in_data.sample_4);

    // even sums and odd rotation products
    st2_e0_r   <= W2'(st1_s07_r) + W2'(st1_s34_r);
    st2_e1_r   <= W2'(st1_s07_r) - W2'(st1_s34_r);
    st2_f0_r   <= W2'(st1_s16_r) + W2'(st1_s25_r);
    st2_f1_r   <= W2'(st1_s16_r) - W2'(st1_s25_r);
    st2_p_r[0] <= mulk(W4'(st1_d34_r), KC_C3);
    st2_p_r[1] <= mulk(W4'(st1_d07_r), KC_S3);
    st2_p_r[2] <= mulk(W4'(st1_d07_r), KC_C3);
    st2_p_r[3] <= mulk(W4'(st1_d34_r), KC_S3);
    st2_p_r[4] <= mulk(W4'(st1_d25_r), KC_C1);
    st2_p_r[5] <= mulk(W4'(st1_d16_r), KC_S1);
    st2_p_r[6] <= mulk(W4'(st1_d16_r), KC_C1);
    st2_p_r[7] <= mulk(W4'(st1_d25_r), KC_S1);

    // odd rotation sums, even products
    st3_ux_r   <= W2'(rnd(st2_p_r[0]) + rnd(st2_p_r[1]));
    st3_uy_r   <= W2'(rnd(st2_p_r[2]) - rnd(st2_p_r[3]));
    st3_vx_r   <= W2'(rnd(st2_p_r[4]) + rnd(st2_p_r[5]));
    st3_vy_r   <= W2'(rnd(st2_p_r[6]) - rnd(st2_p_r[7]));
    st3_a0_r   <= W3'(st2_e0_r) + W3'(st2_f0_r);
    st3_b0_r   <= W3'(st2_e0_r) - W3'(st2_f0_r);
    st3_q_r[0] <= mulk(W4'(st2_f1_r), KC_C6);
    st3_q_r[1] <= mulk(W4'(st2_e1_r), KC_S6);
    st3_q_r[2] <= mulk(W4'(st2_e1_r), KC_C6);
    st3_q_r[3] <= mulk(W4'(st2_f1_r), KC_S6);

    // even rotation sums, odd cross sums, scaling product
    st4_a0_r <= st3_a0_r;
    st4_c0_r <= W3'(rnd(st3_q_r[0]) + rnd(st3_q_r[1]));
    st4_d0_r <= W3'(rnd(st3_q_r[2]) - rnd(st3_q_r[3]));
    st4_a1_r <= W3'(st3_uy_r) + W3'(st3_vx_r);
    st4_c1_r <= W3'(st3_uy_r) - W3'(st3_vx_r);
    st4_d1_r <= W3'(st3_ux_r) + W3'(st3_vy_r);
    st4_b1_r <= W3'(st3_ux_r) - W3'(st3_vy_r);
    st4_pb_r <= mulk(W4'(st3_b0_r), KC_SQ);

    st5_a0_r <= st4_a0_r;
    st5_c0_r <= st4_c0_r;
    st5_d0_r <= st4_d0_r;
    st5_b1_r <= st4_b1_r;
    st5_c1_r <= st4_c1_r;
    st5_c4_r <= rnd(st4_pb_r);
    st5_sa_r <= W4'(st4_a1_r) + W4'(st4_d1_r);
    st5_sd_r <= W4'(st4_a1_r) - W4'(st4_d1_r);

    st6_a0_r <= st5_a0_r;
    st6_c0_r <= st5_c0_r;
    st6_d0_r <= st5_d0_r;
    st6_b1_r <= st5_b1_r;
    st6_c1_r <= st5_c1_r;
    st6_c4_r <= st5_c4_r;
    st6_pa_r <= mulk(st5_sa_r, KC_SQ);
    st6_pd_r <= mulk(st5_sd_r, KC_SQ);

    // round and saturate
    out_data_r.coef_0 <= sat(W4'(st6_a0_r));
    out_data_r.coef_1 <= sat(rnd(st6_pa_r));
    out_data_r.coef_2 <= sat(W4'(st6_c0_r));
    out_data_r.coef_3 <= sat(W4'(st6_c1_r));
    out_data_r.coef_4 <= sat(st6_c4_r);
    out_data_r.coef_5 <= sat(W4'(st6_b1_r));
    out_data_r.coef_6 <= sat(W4'(st6_d0_r));
    out_data_r.coef_7 <= sat(rnd(st6_pd_r));
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_data_r;

  assign dc_sum = OUT_BITS'(in_data.sample_0) + OUT_BITS'(in_data.sample_1)
                + OUT_BITS'(in_data.sample_2) + OUT_BITS'(in_data.sample_3)
                + OUT_BITS'(in_data.sample_4) + OUT_BITS'(in_data.sample_5)
                + OUT_BITS'(in_data.sample_6) + OUT_BITS'(in_data.sample_7);

  `DCT2_ASSERT_DLY(a_beat_latency, start && !busy, LAT, out_valid)
  `DCT2_ASSERT_IMP(a_dc_sum, out_valid, out_data.coef_0 == $past(dc_sum, LAT))
  `DCT2_ASSERT_RANGE(a_coef1_range, out_valid, out_data.coef_1, COEF_HI)
  `DCT2_ASSERT_RANGE(a_coef7_range, out_valid, out_data.coef_7, COEF_HI)

endmodule

`default_nettype wire
